FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the motion mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising edge outside reset.
`define DSMM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("dsmm assertion failed");
// Check that a condition is never true outside reset.
`define DSMM_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("dsmm forbidden condition seen");
`else
`define DSMM_ASSERT(label, clk, rst_n, prop)
`define DSMM_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: rtl/core/dsmm_pkg.sv
// Shared types and constants of the dual-sensor motion mixer.
package dsmm_pkg;

	localparam int DataW   = 16;
	localparam int TimeW   = 32;
	localparam int MaskW   = 2;
	localparam int AxisW   = 2;
	localparam int CfgIdxW = 2;

	// Divider: magnitude of the twist sum is 17 bits, one quotient bit per step.
	localparam int DivW     = DataW + 1;
	localparam int DivSteps = DivW;
	localparam int DivCntW  = $clog2(DivSteps + 1);

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_POINTER_IVL = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_WHEEL_IVL   = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_TWIST_DIV   = 2'd2;

	// Input axis codes.
	localparam logic [AxisW-1:0] AXIS_REL_X = 2'd0;
	localparam logic [AxisW-1:0] AXIS_REL_Y = 2'd1;

	// Report axis codes.
	localparam logic [AxisW-1:0] REP_PTR_X = 2'd0;
	localparam logic [AxisW-1:0] REP_PTR_Y = 2'd1;
	localparam logic [AxisW-1:0] REP_WHEEL = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_EMIT_X,
		ST_EMIT_Y,
		ST_EMIT_W
	} dsmm_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic start;
		logic step;
		logic load_x;
		logic load_y;
		logic load_w;
	} dsmm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic emit_x;
		logic emit_y;
		logic emit_w;
		logic slot_free;
	} dsmm_sts_t;

endpackage

FILE: rtl/core/dsmm_datapath.sv
// Datapath of the motion mixer: sums, timers, serial divider and output register.
`include "assert_macros.svh"

module dsmm_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dsmm_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [dsmm_pkg::DataW-1:0]       cfg_wdata,
	input  logic [dsmm_pkg::MaskW-1:0]       in_mask,
	input  logic [dsmm_pkg::AxisW-1:0]       in_axis,
	input  logic signed [dsmm_pkg::DataW-1:0] in_delta,
	input  logic [dsmm_pkg::TimeW-1:0]       in_now,
	input  dsmm_pkg::dsmm_cmd_t              cmd,
	output dsmm_pkg::dsmm_sts_t              sts,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [dsmm_pkg::AxisW-1:0]       out_axis,
	output logic signed [dsmm_pkg::DataW-1:0] out_value,
	output logic                             out_sync,
	output logic                             out_last
);
	import dsmm_pkg::*;

	logic [DataW-1:0]   ptr_ivl_q, whl_ivl_q, twist_div_q;
	logic [DataW-1:0]   sum_x_q, sum_y_q, twist_a_q, twist_b_q;
	logic [TimeW-1:0]   ptr_stamp_q, whl_stamp_q, now_q;
	logic               p_x_q, p_y_q, w_due_q, neg_q;
	logic [DivW-1:0]    quo_q;
	logic [DivW-1:0]    rem_q;
	logic [DivCntW-1:0] cnt_q;
	logic               out_valid_q;
	logic [AxisW-1:0]   out_axis_q;
	logic [DataW-1:0]   out_value_q;
	logic               out_sync_q, out_last_q;

	logic               xs, ys, ax_x, ax_y;
	logic [TimeW-1:0]   ptr_elapsed, whl_elapsed;
	logic               ptr_due;
	logic [DivW-1:0]    twist_sum, twist_mag;
	logic [DataW-1:0]   div_eff;
	logic [DivW-1:0]    dsr;
	logic [DivW:0]      rem_sh, rem_next;
	logic               rem_ge;
	logic [DivW-1:0]    quo_signed;
	logic               emit_w;
	logic               slot_free, load_any;

	// Configuration registers; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_ivl_q   <= '0;
			whl_ivl_q   <= '0;
			twist_div_q <= DataW'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POINTER_IVL: ptr_ivl_q   <= cfg_wdata;
				CFG_WHEEL_IVL:   whl_ivl_q   <= cfg_wdata;
				CFG_TWIST_DIV:   twist_div_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Event decode.
	assign xs   = in_mask[0];
	assign ys   = in_mask[1];
	assign ax_x = (in_axis == AXIS_REL_X);
	assign ax_y = (in_axis == AXIS_REL_Y);

	// Interval checks use wrap-around elapsed time.
	assign ptr_elapsed = now_q - ptr_stamp_q;
	assign whl_elapsed = now_q - whl_stamp_q;
	assign ptr_due     = ptr_elapsed > {{(TimeW-DataW){1'b0}}, ptr_ivl_q};

	// Sign-extended twist total and its magnitude for the divider.
	assign twist_sum = {twist_a_q[DataW-1], twist_a_q} + {twist_b_q[DataW-1], twist_b_q};
	assign twist_mag = twist_sum[DivW-1] ? (DivW'(0) - twist_sum) : twist_sum;

	// Divisor is twice the configured value, with zero taken as one.
	assign div_eff = (twist_div_q == '0) ? DataW'(1) : twist_div_q;
	assign dsr     = {div_eff, 1'b0};

	// One restoring division step.
	assign rem_sh   = {rem_q, quo_q[DivW-1]};
	assign rem_ge   = rem_sh >= {1'b0, dsr};
	assign rem_next = rem_ge ? (rem_sh - {1'b0, dsr}) : rem_sh;

	// Quotient truncated toward zero, sign restored.
	assign quo_signed = neg_q ? (DivW'(0) - quo_q) : quo_q;
	assign emit_w     = w_due_q && (quo_q != '0);

	assign slot_free = !out_valid_q || out_ready;
	assign load_any  = cmd.load_x || cmd.load_y || cmd.load_w;

	// Input capture and accumulation, and clearing on report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			twist_a_q   <= '0;
			twist_b_q   <= '0;
			ptr_stamp_q <= '0;
			whl_stamp_q <= '0;
		end else begin
			if (cmd.accept) begin
				if (xs && ax_x) sum_x_q   <= sum_x_q + $unsigned(in_delta);
				if (ys && ax_y) sum_y_q   <= sum_y_q + $unsigned(in_delta);
				if (xs && ax_y) twist_a_q <= twist_a_q + $unsigned(in_delta);
				if (ys && ax_x) twist_b_q <= twist_b_q + $unsigned(in_delta);
			end
			if (cmd.load_x) begin
				sum_x_q     <= '0;
				ptr_stamp_q <= now_q;
			end
			if (cmd.load_y) begin
				sum_y_q     <= '0;
				ptr_stamp_q <= now_q;
			end
			if (cmd.load_w) begin
				twist_a_q   <= '0;
				twist_b_q   <= '0;
				whl_stamp_q <= now_q;
			end
		end
	end

	// Timestamp of the transaction under work.
	always_ff @(posedge clk) begin
		if (cmd.accept) now_q <= in_now;
	end

	// Report decisions and the serial divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			p_x_q   <= 1'b0;
			p_y_q   <= 1'b0;
			w_due_q <= 1'b0;
		end else if (cmd.start) begin
			p_x_q   <= ptr_due && (sum_x_q != '0);
			p_y_q   <= ptr_due && (sum_y_q != '0);
			w_due_q <= whl_elapsed > {{(TimeW-DataW){1'b0}}, whl_ivl_q};
			cnt_q   <= DivCntW'(DivSteps);
		end else if (cmd.step) begin
			cnt_q <= cnt_q - DivCntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			neg_q <= twist_sum[DivW-1];
			quo_q <= twist_mag;
			rem_q <= '0;
		end else if (cmd.step) begin
			quo_q <= {quo_q[DivW-2:0], rem_ge};
			rem_q <= rem_next[DivW-1:0];
		end
	end

	// Output register; the next result loads once the current one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_any) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			out_axis_q  <= REP_PTR_X;
			out_value_q <= sum_x_q;
			out_sync_q  <= !p_y_q;
			out_last_q  <= !p_y_q && !emit_w;
		end else if (cmd.load_y) begin
			out_axis_q  <= REP_PTR_Y;
			out_value_q <= sum_y_q;
			out_sync_q  <= 1'b1;
			out_last_q  <= !emit_w;
		end else if (cmd.load_w) begin
			out_axis_q  <= REP_WHEEL;
			out_value_q <= quo_signed[DataW-1:0];
			out_sync_q  <= 1'b1;
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_axis  = out_axis_q;
	assign out_value = $signed(out_value_q);
	assign out_sync  = out_sync_q;
	assign out_last  = out_last_q;

	// Status toward the controller.
	assign sts.div_done  = (cnt_q == '0);
	assign sts.emit_x    = p_x_q;
	assign sts.emit_y    = p_y_q;
	assign sts.emit_w    = emit_w;
	assign sts.slot_free = slot_free;

	`DSMM_ASSERT(a_load_needs_slot, clk, arst_n, load_any |-> slot_free)
	`DSMM_ASSERT(a_wheel_clears, clk, arst_n, cmd.load_w |=> (twist_a_q == '0 && twist_b_q == '0))
	`DSMM_NEVER(a_step_past_end, clk, arst_n, cmd.step && (cnt_q == '0))

endmodule

FILE: rtl/core/dsmm_ctrl.sv
// Controller state machine of the motion mixer.
`include "assert_macros.svh"

module dsmm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dsmm_pkg::dsmm_sts_t sts,
	output dsmm_pkg::dsmm_cmd_t cmd
);
	import dsmm_pkg::*;

	dsmm_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_START;
			end
			ST_START: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					priority if (sts.emit_x) state_d = ST_EMIT_X;
					else if (sts.emit_y)     state_d = ST_EMIT_Y;
					else if (sts.emit_w)     state_d = ST_EMIT_W;
					else                     state_d = ST_IDLE;
				end
			end
			ST_EMIT_X: begin
				if (sts.slot_free) begin
					priority if (sts.emit_y) state_d = ST_EMIT_Y;
					else if (sts.emit_w)     state_d = ST_EMIT_W;
					else                     state_d = ST_IDLE;
				end
			end
			ST_EMIT_Y: begin
				if (sts.slot_free) state_d = sts.emit_w ? ST_EMIT_W : ST_IDLE;
			end
			ST_EMIT_W: begin
				if (sts.slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_START:  cmd.start  = 1'b1;
			ST_DIV:    cmd.step   = !sts.div_done;
			ST_EMIT_X: cmd.load_x = sts.slot_free;
			ST_EMIT_Y: cmd.load_y = sts.slot_free;
			ST_EMIT_W: cmd.load_w = sts.slot_free;
			default: ;
		endcase
	end

	`DSMM_ASSERT(a_accept_starts, clk, arst_n, cmd.accept |=> (state_q == ST_START))
	`DSMM_ASSERT(a_div_holds, clk, arst_n,
		(state_q == ST_DIV && !sts.div_done) |=> (state_q == ST_DIV))
	`DSMM_ASSERT(a_one_load, clk, arst_n, $onehot0({cmd.load_x, cmd.load_y, cmd.load_w}))

endmodule

FILE: rtl/core/dual_sensor_motion_mixer_top.sv
// Top level of the dual-sensor motion mixer.
//
// Takes one motion event per input transaction and works on it alone: it accepts
// and accumulates the event, decides the pointer and wheel intervals and loads the
// divider, runs a restoring divider (one quotient bit per cycle) for the wheel
// value, sees the divider finish and picks the first result, then loads each
// result (pointer X, pointer Y, wheel) into the output register as its slot frees.
// A result sits in the output register while the next event is accepted. The user
// must write configuration only while no event is in work; the block itself does
// not enforce this.

module dual_sensor_motion_mixer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [dsmm_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [dsmm_pkg::DataW-1:0]   cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // [15:0] delta, [47:16] now_ms
	input  logic [3:0]  s_tuser,  // [1:0] sensor_mask, [3:2] axis_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [15:0] report_value
	output logic [2:0]  m_tuser,  // [1:0] report_axis, [2] report_sync
	output logic        m_tlast   // last_of_run
);
	import dsmm_pkg::*;

	dsmm_cmd_t                cmd;
	dsmm_sts_t                sts;
	logic [AxisW-1:0]         out_axis;
	logic signed [DataW-1:0]  out_value;
	logic                     out_sync;

	dsmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dsmm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_mask   (s_tuser[1:0]),
		.in_axis   (s_tuser[3:2]),
		.in_delta  ($signed(s_tdata[15:0])),
		.in_now    (s_tdata[47:16]),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_axis  (out_axis),
		.out_value (out_value),
		.out_sync  (out_sync),
		.out_last  (m_tlast)
	);

	assign m_tdata = $unsigned(out_value);
	assign m_tuser = {out_sync, out_axis};

endmodule
